// ===== hw/rtl/dfs_pkg.sv =====
package dfs_pkg;

  // Frame geometry.
  localparam int PACKET_BYTES = 256;
  localparam int HEADER_BYTES = 2;
  localparam int STAMP_BYTES  = 12;

  localparam int PTR_W     = $clog2(PACKET_BYTES);
  localparam int OFF_W     = $clog2(PACKET_BYTES + 1);
  localparam int SUM_W     = OFF_W + 1;
  localparam int PAY_START = HEADER_BYTES + STAMP_BYTES;
  // First offset past the payload, where the end delimiter begins.
  localparam int PAY_END   = PACKET_BYTES - 2;

  // Delimiter bytes.
  localparam logic [7:0] START_0 = 8'hB2;
  localparam logic [7:0] START_1 = 8'h55;
  localparam logic [7:0] END_0   = 8'h75;
  localparam logic [7:0] END_1   = 8'h9F;

  // Time stamp and microseconds scaling.
  localparam int NS_PER_US = 1000;
  localparam int SEC_W     = 64;
  localparam int DIV_W     = 32;
  localparam int STAMP_W   = STAMP_BYTES * 8;
  localparam int MICROS_W  = 23;
  // Nanoseconds / 1000 as (ns * ceil(2^38 / 1000)) >> 38, exact for any 32-bit value.
  localparam int MUL_W        = 29;
  localparam int MICROS_SHIFT = 38;
  localparam int PROD_W       = DIV_W + MUL_W;
  localparam logic [MUL_W-1:0] MICROS_MUL = 29'd274877907;

  // Output word.
  localparam int WORD_W      = 64;
  localparam int BYTES_W     = 4;
  localparam int WORD_BYTES  = WORD_W / 8;
  localparam int OUT_RAW_W   = WORD_W + BYTES_W + SEC_W + MICROS_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - OUT_RAW_W;

  // Frame queue between the search and the unpacking sides.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0] ring_ptr_t;
  typedef logic [OFF_W-1:0] ring_off_t;

  typedef enum logic {
    F_IDLE,
    F_CHECK
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_t;

  // Unpacking side status, seen by the search side to protect unread bytes.
  typedef struct packed {
    logic      busy;
    ring_off_t off;
  } back_stat_t;

  // Ring address of offset k past slot p.
  function automatic ring_ptr_t ring_add(ring_ptr_t p, ring_off_t k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(k);
    if (s >= SUM_W'(PACKET_BYTES)) begin
      s = s - SUM_W'(PACKET_BYTES);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dfs_ram.sv =====
module dfs_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/dfs_queue.sv =====
module dfs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dfs_pkg::ring_ptr_t push_data,
  input  logic              pop,
  output logic              empty,
  output dfs_pkg::ring_ptr_t pop_data
);
  import dfs_pkg::*;

  ring_ptr_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Frame base addresses.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("frame queue read while empty");

endmodule

// ===== hw/rtl/dfs_front.sv =====
module dfs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  dfs_pkg::back_stat_t back_stat,
  output logic                ram_we,
  output dfs_pkg::ring_ptr_t  ram_waddr,
  output logic [7:0]          ram_wdata,
  output dfs_pkg::ring_ptr_t  ram_raddr,
  input  logic [7:0]          ram_rdata,
  output logic                q_push,
  output dfs_pkg::ring_ptr_t  q_base
);
  import dfs_pkg::*;

  front_state_t state_r;
  front_state_t state_nxt;
  ring_ptr_t    wp_r;
  ring_off_t    fill_r;
  logic [7:0]   byte_r;
  logic [7:0]   prev_byte_r;
  logic [7:0]   old0_r;
  logic         accept;
  logic         match;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_CHECK;
        end
      end
      F_CHECK: begin
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs. A byte is refused while it would overwrite a byte of the
  // pending frame that the unpacking side has not read yet.
  always_comb begin
    in_tready = (state_r == F_IDLE) && !(back_stat.busy && (fill_r >= back_stat.off));
    accept    = in_tvalid && in_tready;
    ram_we    = accept;
    ram_waddr = wp_r;
    ram_wdata = in_tdata;
    // After this write the second oldest byte sits two slots ahead.
    ram_raddr = ring_add(wp_r, OFF_W'(2));
    match     = (fill_r == OFF_W'(PACKET_BYTES)) && (old0_r == START_0) &&
                (ram_rdata == START_1) && (prev_byte_r == END_0) && (byte_r == END_1);
    q_push    = (state_r == F_CHECK) && match;
    q_base    = wp_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        wp_r <= ring_add(wp_r, OFF_W'(1));
        if (fill_r != OFF_W'(PACKET_BYTES)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (q_push) begin
        fill_r <= '0;
      end
    end
  end

  // Newest two bytes, and the oldest byte carried from the previous read.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r      <= in_tdata;
      prev_byte_r <= byte_r;
    end
    if (state_r == F_CHECK) begin
      old0_r <= ram_rdata;
    end
  end

  a_check_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_CHECK) |-> !in_tready)
    else $error("byte accepted during delimiter check");

endmodule

// ===== hw/rtl/dfs_back.sv =====
module dfs_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  dfs_pkg::ring_ptr_t                q_base,
  output logic                              q_pop,
  output dfs_pkg::ring_ptr_t                ram_raddr,
  input  logic [7:0]                        ram_rdata,
  output dfs_pkg::back_stat_t               back_stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dfs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import dfs_pkg::*;

  back_state_t         state_r;
  back_state_t         state_nxt;
  ring_ptr_t           base_r;
  ring_off_t           off_r;
  logic                pend_r;
  ring_off_t           pend_off_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [WORD_W-1:0]   wbuf_r;
  logic [BYTES_W-1:0]  wcnt_r;
  logic                wfull_r;
  logic                wlast_r;
  logic                first_pend_r;
  logic                div_go_r;
  logic                div_done_r;
  logic [MICROS_W-1:0] quo_r;
  logic                out_vld_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [BYTES_W-1:0]  out_bytes_r;
  logic [SEC_W-1:0]    out_sec_r;
  logic [MICROS_W-1:0] out_mic_r;
  logic                out_first_r;
  logic                out_last_r;

  logic                pend_pay;
  ring_off_t           pay_idx;
  logic                pend_end;
  logic                issue;
  logic                load;
  logic [PROD_W-1:0]   mic_prod;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_READ;
        end
      end
      B_READ: begin
        if (load && wlast_r) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    pend_pay  = pend_off_r >= OFF_W'(PAY_START);
    pay_idx   = pend_off_r - OFF_W'(PAY_START);
    pend_end  = pend_r && pend_pay &&
                ((pay_idx[2:0] == 3'd7) || (pend_off_r == OFF_W'(PAY_END - 1)));
    // Reads stop while a finished word waits for the output register.
    issue     = (state_r == B_READ) && !wfull_r && !pend_end &&
                (off_r < OFF_W'(PAY_END));
    load      = wfull_r && (!out_vld_r || out_tready) && (!first_pend_r || div_done_r);
    q_pop     = (state_r == B_IDLE) && !q_empty;
    ram_raddr = ring_add(base_r, off_r);
    back_stat.busy = (state_r == B_READ) || !q_empty;
    back_stat.off  = (state_r == B_READ) ? off_r : '0;
    mic_prod  = PROD_W'(stamp_r[SEC_W +: DIV_W]) * PROD_W'(MICROS_MUL);
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {PAD_W'(0), out_mic_r, out_sec_r, out_bytes_r, out_word_r};
  assign out_tuser  = out_first_r;
  assign out_tlast  = out_last_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      pend_r     <= 1'b0;
      wfull_r    <= 1'b0;
      div_go_r   <= 1'b0;
      div_done_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= issue;
      div_go_r <= pend_r && (pend_off_r == OFF_W'(PAY_START - 1));
      if (pend_end) begin
        wfull_r <= 1'b1;
      end else if (load) begin
        wfull_r <= 1'b0;
      end
      // Microseconds are ready in the cycle after the stamp is complete.
      if (q_pop) begin
        div_done_r <= 1'b0;
      end else if (div_go_r) begin
        div_done_r <= 1'b1;
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Frame unpacking datapath.
  always_ff @(posedge clk) begin
    pend_off_r <= off_r;
    if (q_pop) begin
      base_r       <= q_base;
      off_r        <= OFF_W'(HEADER_BYTES);
      wbuf_r       <= '0;
      wcnt_r       <= '0;
      first_pend_r <= 1'b1;
    end else begin
      if (issue) begin
        off_r <= off_r + 1'b1;
      end
      // Captured byte goes to the time stamp or to the current word.
      if (pend_r && !pend_pay) begin
        stamp_r <= {ram_rdata, stamp_r[STAMP_W-1:8]};
      end else if (pend_r) begin
        wbuf_r[{wcnt_r[2:0], 3'b000} +: 8] <= ram_rdata;
        wcnt_r <= wcnt_r + 1'b1;
        if (pend_end) begin
          wlast_r <= (pend_off_r == OFF_W'(PAY_END - 1));
        end
      end
      if (load) begin
        wbuf_r       <= '0;
        wcnt_r       <= '0;
        first_pend_r <= 1'b0;
      end
    end
    // Microseconds from the nanoseconds field by reciprocal multiplication.
    if (div_go_r) begin
      quo_r <= mic_prod[PROD_W-1:MICROS_SHIFT];
    end
    // Output register.
    if (load) begin
      out_word_r  <= wbuf_r;
      out_bytes_r <= wcnt_r;
      out_sec_r   <= first_pend_r ? stamp_r[SEC_W-1:0] : '0;
      out_mic_r   <= first_pend_r ? quo_r : '0;
      out_first_r <= first_pend_r;
      out_last_r  <= wlast_r;
    end
  end

  a_word_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_bytes_r != '0) && (out_bytes_r <= BYTES_W'(WORD_BYTES)))
    else $error("payload word with bad byte count");

  a_no_capture_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !wfull_r)
    else $error("byte captured while word buffer full");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE) |-> !pend_r && !wfull_r && !issue)
    else $error("unpacking activity outside a frame");

endmodule

// ===== hw/rtl/delimited_frame_sync_top.sv =====
// Each accepted byte is followed by a delimiter check against the ring, during which no byte
// is taken. Input also stalls while a found frame waits in the queue, and whenever a new byte
// would overwrite an unread byte of a pending frame. The first payload word of a frame is
// presented once the stamp and its first eight payload bytes are read; later words as theirs are.
// Reset: synchronous, active low; clears pointers, fill count and all valid flags.
// The 256-byte window memory is not cleared; it is only tested once fully rewritten.
module delimited_frame_sync_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] stream_byte
  input  logic [7:0]                      in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [63:0] payload_word, [67:64] word_bytes, [131:68] stamp_seconds,
  // [154:132] stamp_micros, [159:155] zero
  output logic [dfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] first_word
  output logic                            out_tuser,
  // last_word
  output logic                            out_tlast
);
  import dfs_pkg::*;

  logic       ram_we;
  ring_ptr_t  ram_waddr;
  logic [7:0] ram_wdata;
  ring_ptr_t  ram_raddr_a;
  logic [7:0] ram_rdata_a;
  ring_ptr_t  ram_raddr_b;
  logic [7:0] ram_rdata_b;
  logic       q_push;
  ring_ptr_t  q_push_base;
  logic       q_pop;
  logic       q_empty;
  ring_ptr_t  q_pop_base;
  back_stat_t back_stat;

  // Byte window shared by the search and unpacking sides.
  dfs_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  // Delimiter search.
  dfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .back_stat (back_stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr_a),
    .ram_rdata (ram_rdata_a),
    .q_push    (q_push),
    .q_base    (q_push_base)
  );

  // Found frames waiting to be unpacked.
  dfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_base),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_pop_base)
  );

  // Stamp extraction and payload word packing.
  dfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_base     (q_pop_base),
    .q_pop      (q_pop),
    .ram_raddr  (ram_raddr_b),
    .ram_rdata  (ram_rdata_b),
    .back_stat  (back_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/delimited_frame_sync_top_tb.sv =====
`timescale 1ns / 1ps

module delimited_frame_sync_top_tb;
  import dfs_pkg::*;

  localparam int MAX_FRAME_WORDS = 64;
  localparam int STREAM_ITEMS    = 470;
  localparam int DRAIN_CYCLES    = 400;

  // One payload word as the block should present it.
  typedef struct {
    logic [WORD_W-1:0]   payload_word;
    logic [BYTES_W-1:0]  word_bytes;
    logic [SEC_W-1:0]    stamp_seconds;
    logic [MICROS_W-1:0] stamp_micros;
    logic                first_word;
    logic                last_word;
  } frame_word_t;

  // Tracks the byte window and holds the payload words still due from the block.
  class frame_word_predictor;
    logic [7:0]  ring [PACKET_BYTES];
    int unsigned wr_ptr;
    int unsigned fill;
    int unsigned errors;
    int unsigned frames_found;
    frame_word_t expected_words [$];

    function new();
      wr_ptr       = 0;
      fill         = 0;
      errors       = 0;
      frames_found = 0;
    endfunction

    // Byte k of the full window, oldest first.
    function logic [7:0] byte_at(int unsigned k);
      return ring[(wr_ptr + k) % PACKET_BYTES];
    endfunction

    // Little-endian value of n window bytes starting at offset k.
    function logic [63:0] le_value(int unsigned k, int unsigned n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) begin
        v |= 64'(byte_at(k + i)) << (8 * i);
      end
      return v;
    endfunction

    // Shift one accepted byte into the window and queue the words of a found frame.
    function void note_byte(logic [7:0] b);
      frame_word_t w;
      logic [SEC_W-1:0] secs;
      logic [31:0] nanos;
      int pay_len;
      int nwords;
      int cnt;
      ring[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % PACKET_BYTES;
      if (fill < PACKET_BYTES) begin
        fill++;
      end
      if (fill < PACKET_BYTES) begin
        return;
      end
      if (byte_at(0) != START_0 || byte_at(1) != START_1 ||
          byte_at(PACKET_BYTES - 2) != END_0 || byte_at(PACKET_BYTES - 1) != END_1) begin
        return;
      end
      secs  = le_value(HEADER_BYTES, 8);
      nanos = le_value(HEADER_BYTES + 8, 4);
      fill  = 0;
      frames_found++;
      pay_len = PACKET_BYTES - PAY_START - 2;
      // A frame without payload still reports its time stamp in one word.
      if (pay_len <= 0) begin
        w.payload_word  = '0;
        w.word_bytes    = '0;
        w.stamp_seconds = secs;
        w.stamp_micros  = MICROS_W'(nanos / NS_PER_US);
        w.first_word    = 1'b1;
        w.last_word     = 1'b1;
        expected_words.push_back(w);
        return;
      end
      nwords = (pay_len + WORD_BYTES - 1) / WORD_BYTES;
      if (nwords > MAX_FRAME_WORDS) begin
        nwords = MAX_FRAME_WORDS;
      end
      for (int i = 0; i < nwords; i++) begin
        cnt = pay_len - WORD_BYTES * i;
        if (cnt > WORD_BYTES) begin
          cnt = WORD_BYTES;
        end
        w.payload_word  = le_value(PAY_START + WORD_BYTES * i, cnt);
        w.word_bytes    = BYTES_W'(cnt);
        w.stamp_seconds = (i == 0) ? secs : '0;
        w.stamp_micros  = (i == 0) ? MICROS_W'(nanos / NS_PER_US) : '0;
        w.first_word    = (i == 0);
        w.last_word     = (i + 1 == nwords);
        expected_words.push_back(w);
      end
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one transferred word with the oldest outstanding word.
    function void check_word(logic [OUT_TDATA_W-1:0] d, logic first_w, logic last_w);
      frame_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected payload word %0h", d[WORD_W-1:0]);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      compare_field("payload_word", e.payload_word, d[WORD_W-1:0]);
      compare_field("word_bytes", 64'(e.word_bytes), 64'(d[WORD_W +: BYTES_W]));
      compare_field("stamp_seconds", e.stamp_seconds, d[WORD_W + BYTES_W +: SEC_W]);
      compare_field("stamp_micros", 64'(e.stamp_micros),
                    64'(d[WORD_W + BYTES_W + SEC_W +: MICROS_W]));
      compare_field("first_word", 64'(e.first_word), 64'(first_w));
      compare_field("last_word", 64'(e.last_word), 64'(last_w));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  frame_word_predictor predictor;
  int unsigned in_accepted = 0;
  int unsigned burst_left  = 0;
  int unsigned rcv_left    = 0;
  int unsigned rcv_mode    = 0;
  int unsigned rcv_tick    = 0;

  delimited_frame_sync_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predictor.note_byte(in_tdata);
      in_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      predictor.check_word(out_tdata, out_tuser, out_tlast);
    end
  end

  // The receiver switches between always ready, random, sparse and long stalls.
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode = $urandom_range(0, 3);
      rcv_left = $urandom_range(16, 96);
    end else begin
      rcv_left--;
    end
    case (rcv_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (rcv_tick % 4 == 0);
      end
      default: begin
        out_tready <= (rcv_tick % 24 >= 20);
      end
    endcase
    rcv_tick++;
  end

  // Delimiter bytes turn up often so that partial and false matches occur.
  function automatic logic [7:0] stream_noise();
    case ($urandom_range(0, 7))
      0: return START_0;
      1: return START_1;
      2: return END_0;
      3: return END_1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one byte, with a random gap, sometimes none, at the start of each burst; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int unsigned seen;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    seen = in_accepted;
    do @(negedge clk); while (in_accepted == seen);
  endtask

  // Send one frame; a broken frame has one delimiter byte altered. With overlap, the
  // stamp opens with a start delimiter and an end delimiter follows the frame, so a
  // window two bytes later would match if the fill count were not cleared.
  task automatic send_frame(input bit broken, input bit overlap);
    logic [7:0] fr [PACKET_BYTES];
    int k;
    int unsigned sel;
    fr[0] = START_0;
    fr[1] = START_1;
    sel = $urandom_range(0, 3);
    for (k = HEADER_BYTES; k < PAY_START; k++) begin
      fr[k] = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
    end
    for (k = PAY_START; k < PAY_END; k++) begin
      fr[k] = ($urandom_range(0, 15) == 0) ? stream_noise() : 8'($urandom);
    end
    fr[PAY_END]     = END_0;
    fr[PAY_END + 1] = END_1;
    if (overlap) begin
      fr[HEADER_BYTES]     = START_0;
      fr[HEADER_BYTES + 1] = START_1;
    end
    if (broken) begin
      case ($urandom_range(0, 3))
        0: k = 0;
        1: k = 1;
        2: k = PAY_END;
        default: k = PAY_END + 1;
      endcase
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < PACKET_BYTES; k++) begin
      send_byte(fr[k]);
    end
    if (overlap) begin
      send_byte(END_0);
      send_byte(END_1);
    end
  endtask

  initial begin
    logic [7:0] directed [16];
    bit paused_once;
    int unsigned pick;
    directed = '{8'h00, 8'hFF, 8'h01, 8'h80, START_0, START_1, END_0,
                 END_1, START_0, START_1, END_0, END_1, 8'h55, 8'hAA,
                 8'h0F, 8'hF0};
    predictor  = new();
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    paused_once = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed bytes while the window is still filling, then a frame that invites overlap.
    foreach (directed[i]) begin
      send_byte(directed[i]);
    end
    send_frame(1'b0, 1'b1);

    // Mostly well-formed frames with random content, some broken frames and noise.
    while (in_accepted < STREAM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(1'b0, $urandom_range(0, 5) == 0);
      end else if (pick < 8) begin
        send_frame(1'b1, 1'b0);
      end else begin
        repeat ($urandom_range(1, 40)) send_byte(stream_noise());
      end
      // Now and then hold the stream until the block has delivered every word.
      if (predictor.frames_found > 0 && (!paused_once || $urandom_range(0, 3) == 0)) begin
        paused_once = 1'b1;
        in_tvalid <= 1'b0;
        do @(negedge clk); while (predictor.expected_words.size() != 0);
      end
    end

    // Drain the remaining words, then watch for stray ones.
    in_tvalid <= 1'b0;
    do @(negedge clk); while (predictor.expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (predictor.errors == 0 && predictor.expected_words.size() == 0) begin
      $display("delimited_frame_sync_top_tb OK");
    end else begin
      $display("delimited_frame_sync_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("delimited_frame_sync_top_tb NOT OK");
    $finish;
  end

endmodule
